@@ rtl/prpd_pkg.sv @@
// Package for the pulse-rate peak detector: shared types, codes and constants.
// Used by prpd_ctrl, prpd_datapath and pulse_rate_peak_detector.
`default_nettype none
package prpd_pkg;
  localparam int AVG_DEPTH_DEF = 8;
  localparam logic [16:0] BPM_NUM = 17'd60000;
  localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [11:0] SAMPLE_MAX = 12'd4095;

  localparam logic [2:0] REG_START_THR = 3'd0;
  localparam logic [2:0] REG_HYST = 3'd1;
  localparam logic [2:0] REG_COOLDOWN = 3'd2;
  localparam logic [2:0] REG_MIN_BEATS = 3'd3;
  localparam logic [2:0] REG_ADAPT = 3'd4;
  localparam logic [2:0] REG_MIN_BPM = 3'd5;
  localparam logic [2:0] REG_MAX_BPM = 3'd6;

  localparam logic [1:0] ST_SAMPLING = 2'd0;
  localparam logic [1:0] ST_READING = 2'd1;
  localparam logic [1:0] ST_NO_PULSE = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_DIV1_CHK, S_DIV2, S_DIV2_CHK, S_SUM, S_AVG, S_OUT
  } state_t;

  typedef struct packed {
    logic sample;     // run the per-sample update
    logic div1_start; // total / count
    logic div2_start; // 60000 / avg
    logic div_step;
    logic push;       // write bpm into filter, start sum walk
    logic sum_step;
    logic avg_start;  // sum / fill
    logic finish;     // load result register; close window unless a sample is taken
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic avg_zero;
    logic bpm_bad;
    logic sum_done;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/pulse_rate_peak_detector.sv @@
// Pulse-rate peak detector: a sample that does not end a window has its result
// registered in the cycle after its transfer, and the next sample is taken no
// earlier than the cycle after that result is transferred. The last sample of
// a window runs the shared 20-step radix-2 divider: for a new reading its
// result follows two divisions, the walk over the filled averaging store and
// the averaging division; an out-of-range bpm ends after the second division
// and a window with no reliable pulse after the first. A new sample is taken
// once the previous result has been transferred.
`default_nettype none
module pulse_rate_peak_detector #(
  parameter int AVG_DEPTH = prpd_pkg::AVG_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // sample_value[11:0], time_ms[27:12], zeros
  input  wire logic        in_tlast,  // window_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // status[1:0], reading_bpm[9:2], threshold_now[21:10]
  output logic             out_tuser, // beat_seen
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  prpd_pkg::cmd_t cmd;
  prpd_pkg::sts_t sts;
  logic in_fire, busy;
  logic [1:0] st;
  logic [7:0] bpm;
  logic [11:0] thr;

  assign in_fire = in_tvalid && in_tready;
  assign out_tvalid = busy;

  prpd_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(busy), .sts, .in_ready(in_tready), .cmd
  );

  prpd_datapath #(.AVG_DEPTH(AVG_DEPTH)) u_dp (
    .clk, .rst_n,
    .sample_value(in_tdata[11:0]), .time_ms(in_tdata[27:12]), .window_end(in_tlast),
    .cfg_we, .cfg_addr, .cfg_wdata, .cmd,
    .out_take(out_tvalid && out_tready), .sts, .out_busy(busy),
    .res_status(st), .res_bpm(bpm), .res_beat(out_tuser), .res_thr(thr)
  );

  assign out_tdata = {2'b00, thr, bpm, st};
endmodule
`default_nettype wire

@@ rtl/prpd_ctrl.sv @@
// Controller for the pulse-rate peak detector: sequences the window-end work.
// Depends on prpd_pkg.
`default_nettype none
module prpd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_busy,
  input  wire prpd_pkg::sts_t  sts,
  output logic                 in_ready,
  output prpd_pkg::cmd_t       cmd
);
  prpd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= prpd_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      prpd_pkg::S_IDLE: begin
        in_ready = rst_n && !out_busy;
        if (in_fire) begin
          cmd.sample = 1'b1;
          if (sts.last) state_nxt = prpd_pkg::S_DIV1;
          else begin
            cmd.finish = 1'b1;
            cmd.status = prpd_pkg::ST_SAMPLING;
          end
        end
      end
      prpd_pkg::S_DIV1: begin
        // adapt the threshold and load total / count
        cmd.div1_start = 1'b1;
        state_nxt = prpd_pkg::S_DIV1_CHK;
      end
      prpd_pkg::S_DIV1_CHK: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = prpd_pkg::S_DIV2;
      end
      prpd_pkg::S_DIV2: begin
        if (sts.avg_zero) begin
          cmd.finish = 1'b1;
          cmd.status = prpd_pkg::ST_NO_PULSE;
          state_nxt = prpd_pkg::S_IDLE;
        end else begin
          cmd.div2_start = 1'b1;
          state_nxt = prpd_pkg::S_DIV2_CHK;
        end
      end
      prpd_pkg::S_DIV2_CHK: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = prpd_pkg::S_SUM;
      end
      prpd_pkg::S_SUM: begin
        if (sts.bpm_bad) begin
          cmd.finish = 1'b1;
          cmd.status = prpd_pkg::ST_RANGE;
          state_nxt = prpd_pkg::S_IDLE;
        end else begin
          cmd.push = 1'b1;
          state_nxt = prpd_pkg::S_AVG;
        end
      end
      prpd_pkg::S_AVG: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) begin
          cmd.avg_start = 1'b1;
          state_nxt = prpd_pkg::S_OUT;
        end
      end
      prpd_pkg::S_OUT: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          cmd.status = prpd_pkg::ST_READING;
          state_nxt = prpd_pkg::S_IDLE;
        end
      end
      default: state_nxt = prpd_pkg::S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == prpd_pkg::S_IDLE)
    else $error("ready outside idle");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == prpd_pkg::S_IDLE)
    else $error("finish without return to idle");
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.bpm_bad)
    else $error("push of rejected bpm");
endmodule
`default_nettype wire

@@ rtl/prpd_datapath.sv @@
// Datapath for the pulse-rate peak detector: window state, shared radix-2
// divider, averaging filter store and result register. Depends on prpd_pkg.
`default_nettype none
module prpd_datapath #(
  parameter int AVG_DEPTH = prpd_pkg::AVG_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [11:0]     sample_value,
  input  wire logic [15:0]     time_ms,
  input  wire logic            window_end,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_addr,
  input  wire logic [15:0]     cfg_wdata,
  input  wire prpd_pkg::cmd_t  cmd,
  input  wire logic            out_take,
  output prpd_pkg::sts_t       sts,
  output logic                 out_busy,
  output logic [1:0]           res_status,
  output logic [7:0]           res_bpm,
  output logic                 res_beat,
  output logic [11:0]          res_thr
);
  localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FW = $clog2(AVG_DEPTH + 1);
  localparam int SW = 8 + FW;

  logic [11:0] hyst_r, adapt_r;
  logic [15:0] cooldown_r;
  logic [7:0]  min_beats_r, min_bpm_r, max_bpm_r;

  logic [11:0] thr_r, wmax_r, wmin_r;
  logic        above_r, have_prev_r;
  logic [15:0] prev_t_r;
  logic [19:0] total_r;
  logic [7:0]  count_r, last_good_r;
  logic        beat_r;

  logic [7:0]    store_r [AVG_DEPTH];
  logic [PW-1:0] ptr_r, rd_r;
  logic [FW-1:0] fill_r;
  logic [SW-1:0] sum_r;
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;
  logic          walk_r;

  // shared restoring divider, 20-bit dividend
  logic [19:0] dq_r, ddiv_r;
  logic [20:0] drem_r;
  logic [4:0]  dcnt_r;
  logic [20:0] rem_sh;
  logic [19:0] avg_r;
  logic [16:0] bpm_r;

  logic [11:0] s_max, s_min, range;
  logic        cross_now, rearm;
  logic [15:0] gap;
  logic [20:0] tot_add;
  logic [13:0] range3;
  logic [29:0] range_prod;
  logic [15:0] range6;

  // configuration; the start threshold loads straight into thr_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r <= 12'd100; cooldown_r <= 16'd300;
      min_beats_r <= 8'd2; adapt_r <= 12'd100; min_bpm_r <= 8'd30;
      max_bpm_r <= 8'd200;
    end else if (cfg_we) begin
      case (cfg_addr)
        prpd_pkg::REG_START_THR: ;
        prpd_pkg::REG_HYST:      hyst_r <= cfg_wdata[11:0];
        prpd_pkg::REG_COOLDOWN:  cooldown_r <= cfg_wdata;
        prpd_pkg::REG_MIN_BEATS: min_beats_r <= cfg_wdata[7:0];
        prpd_pkg::REG_ADAPT:     adapt_r <= cfg_wdata[11:0];
        prpd_pkg::REG_MIN_BPM:   min_bpm_r <= cfg_wdata[7:0];
        prpd_pkg::REG_MAX_BPM:   max_bpm_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_max = (sample_value > wmax_r) ? sample_value : wmax_r;
    s_min = (sample_value < wmin_r) ? sample_value : wmin_r;
    cross_now = (sample_value > thr_r) && !above_r;
    rearm = (thr_r >= hyst_r) && (sample_value < thr_r - hyst_r);
    gap = time_ms - prev_t_r;
    tot_add = {1'b0, total_r} + {5'd0, gap};
    range = (wmax_r >= wmin_r) ? wmax_r - wmin_r : 12'd0;
    // 6/10 of the range as 3*range/5, the divide by 5 as a reciprocal multiply
    range3 = {2'd0, range} + {1'd0, range, 1'b0};
    range_prod = 30'(range3) * 30'd52429;
    range6 = 16'(range_prod >> 18);
    rem_sh = {drem_r[19:0], dq_r[19]};
  end

  assign sts.last = window_end;
  assign sts.div_done = (dcnt_r == 5'd0);
  assign sts.avg_zero = dq_r == 20'd0 && avg_r == 20'd0 || ddiv_r == 20'd0;
  assign sts.bpm_bad = (bpm_r < {9'd0, min_bpm_r}) || (bpm_r > {9'd0, max_bpm_r});
  assign sts.sum_done = !walk_r && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 12'd2248;
      above_r <= 1'b0; have_prev_r <= 1'b0; prev_t_r <= '0;
      total_r <= '0; count_r <= '0; wmax_r <= '0; wmin_r <= prpd_pkg::SAMPLE_MAX;
      ptr_r <= '0; fill_r <= '0; last_good_r <= '0;
      dcnt_r <= '0; walk_r <= 1'b0; rd_vld_r <= 1'b0; out_busy <= 1'b0;
      beat_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == prpd_pkg::REG_START_THR) thr_r <= cfg_wdata[11:0];
      if (out_take) out_busy <= 1'b0;
      if (cmd.sample) begin
        wmax_r <= s_max; wmin_r <= s_min;
        beat_r <= cross_now;
        if (cross_now) begin
          above_r <= 1'b1; have_prev_r <= 1'b1; prev_t_r <= time_ms;
          if (have_prev_r && gap > cooldown_r) begin
            total_r <= tot_add[20] ? prpd_pkg::TOTAL_MAX : tot_add[19:0];
            if (count_r != 8'd255) count_r <= count_r + 8'd1;
          end
        end else if (rearm) above_r <= 1'b0;
        // clear the quotient and average, and preset the divisor to the count
        dq_r <= '0; avg_r <= '0;
        ddiv_r <= 20'(count_r);
      end
      if (cmd.div1_start) begin
        // count settled after the sample update; zero beats give no reading
        if (count_r < min_beats_r || count_r == 8'd0) ddiv_r <= '0;
        else begin
          dq_r <= total_r; ddiv_r <= {12'd0, count_r};
          drem_r <= '0; dcnt_r <= 5'd20;
        end
        if (range > adapt_r) thr_r <= wmin_r + range6[11:0];
      end
      if (cmd.div_step && dcnt_r != 5'd0) begin
        dcnt_r <= dcnt_r - 5'd1;
        if (rem_sh >= {1'b0, ddiv_r}) begin
          drem_r <= rem_sh - {1'b0, ddiv_r};
          dq_r <= {dq_r[18:0], 1'b1};
        end else begin
          drem_r <= rem_sh;
          dq_r <= {dq_r[18:0], 1'b0};
        end
      end
      if (cmd.div2_start) begin
        avg_r <= dq_r;
        ddiv_r <= dq_r;
        dq_r <= {3'd0, prpd_pkg::BPM_NUM}; drem_r <= '0; dcnt_r <= 5'd20;
      end
      if (cmd.div_step && dcnt_r == 5'd0 && !walk_r && !cmd.avg_start) bpm_r <= dq_r[16:0];
      if (cmd.push) begin
        store_r[ptr_r] <= bpm_r[7:0];
        ptr_r <= (ptr_r == PW'(AVG_DEPTH - 1)) ? '0 : ptr_r + PW'(1);
        if (fill_r != FW'(AVG_DEPTH)) fill_r <= fill_r + FW'(1);
        walk_r <= 1'b1; rd_r <= '0; sum_r <= '0;
      end
      if (walk_r) begin
        rd_data_r <= store_r[rd_r];
        rd_vld_r <= 1'b1;
        if (32'(rd_r) + 1 >= 32'(fill_r)) walk_r <= 1'b0;
        else rd_r <= rd_r + PW'(1);
      end else rd_vld_r <= 1'b0;
      if (rd_vld_r) sum_r <= sum_r + SW'(rd_data_r);
      if (cmd.avg_start) begin
        dq_r <= 20'(sum_r); ddiv_r <= 20'(fill_r); drem_r <= '0; dcnt_r <= 5'd20;
      end
      if (cmd.finish) begin
        out_busy <= 1'b1;
        res_status <= cmd.status;
        res_beat <= cmd.sample ? cross_now : beat_r;
        res_thr <= (cmd.sample && cfg_we && cfg_addr == prpd_pkg::REG_START_THR)
                   ? cfg_wdata[11:0] : thr_r;
        if (cmd.status == prpd_pkg::ST_READING) begin
          last_good_r <= dq_r[7:0];
          res_bpm <= dq_r[7:0];
        end else res_bpm <= last_good_r;
        if (!cmd.sample) begin
          above_r <= 1'b0; have_prev_r <= 1'b0; prev_t_r <= '0;
          total_r <= '0; count_r <= '0; wmax_r <= '0;
          wmin_r <= prpd_pkg::SAMPLE_MAX;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= AVG_DEPTH)
    else $error("filter fill overflow");
  a_walk_fill: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r |-> fill_r != '0)
    else $error("sum walk over empty store");
endmodule
`default_nettype wire

@@ sim/pulse_rate_peak_detector_checker.sv @@
// Checker for the pulse-rate peak detector: watches the config port and both
// stream channels, predicts each result and compares it. Depends on prpd_pkg.
`timescale 1ns / 1ps
module pulse_rate_peak_detector_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  localparam int DEPTH = prpd_pkg::AVG_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  bpm;
    logic        beat;
    logic [11:0] thr;
  } reading_t;

  reading_t expected_readings[$];

  // register copies
  logic [11:0] start_thr, hyst, adapt_range;
  logic [15:0] cooldown;
  logic [7:0]  min_beats, min_bpm, max_bpm;

  // detector state
  logic [11:0] thr, win_max, win_min;
  logic        armed_off, have_peak;
  logic [15:0] peak_time;
  logic [19:0] ibi_total;
  logic [7:0]  ibi_count;
  logic [7:0]  bpm_hist [DEPTH];
  logic [2:0]  hist_ptr;
  logic [3:0]  hist_fill;
  logic [7:0]  good_bpm;

  task automatic restart_window();
    armed_off = 1'b0;
    have_peak = 1'b0;
    peak_time = '0;
    ibi_total = '0;
    ibi_count = '0;
    win_max   = '0;
    win_min   = prpd_pkg::SAMPLE_MAX;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      prpd_pkg::REG_START_THR: begin
        start_thr = val[11:0];
        thr = val[11:0];
      end
      prpd_pkg::REG_HYST:      hyst = val[11:0];
      prpd_pkg::REG_COOLDOWN:  cooldown = val;
      prpd_pkg::REG_MIN_BEATS: min_beats = val[7:0];
      prpd_pkg::REG_ADAPT:     adapt_range = val[11:0];
      prpd_pkg::REG_MIN_BPM:   min_bpm = val[7:0];
      prpd_pkg::REG_MAX_BPM:   max_bpm = val[7:0];
      default: ;
    endcase
  endtask

  task automatic predict_reading(input logic [11:0] s, input logic [15:0] t, input logic last);
    reading_t r;
    logic [15:0] gap;
    int unsigned total, span, mean_ibi, bpm, acc;
    r.status = prpd_pkg::ST_SAMPLING;
    r.bpm = good_bpm;
    r.beat = 1'b0;
    if (s > win_max) win_max = s;
    if (s < win_min) win_min = s;
    if (s > thr && !armed_off) begin
      armed_off = 1'b1;
      r.beat = 1'b1;
      if (have_peak) begin
        gap = t - peak_time;
        if (gap > cooldown) begin
          total = ibi_total + gap;
          ibi_total = (total > prpd_pkg::TOTAL_MAX) ? prpd_pkg::TOTAL_MAX : total[19:0];
          if (ibi_count != 8'd255) ibi_count++;
        end
      end
      peak_time = t;
      have_peak = 1'b1;
    end else if (thr >= hyst && s < thr - hyst) begin
      armed_off = 1'b0;
    end
    if (last) begin
      span = (win_max >= win_min) ? win_max - win_min : 0;
      mean_ibi = 0;
      if (span > adapt_range) thr = 12'(win_min + span * 6 / 10);
      if (ibi_count >= min_beats && ibi_count != 0) mean_ibi = ibi_total / ibi_count;
      if (mean_ibi == 0) begin
        r.status = prpd_pkg::ST_NO_PULSE;
      end else begin
        bpm = prpd_pkg::BPM_NUM / mean_ibi;
        if (bpm < min_bpm || bpm > max_bpm) begin
          r.status = prpd_pkg::ST_RANGE;
        end else begin
          bpm_hist[hist_ptr] = bpm[7:0];
          hist_ptr++;
          if (hist_fill < DEPTH) hist_fill++;
          acc = 0;
          for (int i = 0; i < hist_fill; i++) acc += bpm_hist[i];
          good_bpm = 8'(acc / hist_fill);
          r.bpm = good_bpm;
          r.status = prpd_pkg::ST_READING;
        end
      end
      restart_window();
    end
    r.thr = thr;
    expected_readings.push_back(r);
  endtask

  initial fail_count = 0;
  assign pending = expected_readings.size();

  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      start_thr = 12'd2248; hyst = 12'd100; cooldown = 16'd300; min_beats = 8'd2;
      adapt_range = 12'd100; min_bpm = 8'd30; max_bpm = 8'd200;
      thr = start_thr;
      restart_window();
      hist_ptr = '0; hist_fill = '0; good_bpm = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we) write_reg(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) predict_reading(in_tdata[11:0], in_tdata[27:12], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result transfer: tdata=%h tuser=%b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          e = expected_readings.pop_front();
          if (out_tdata[1:0] !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_tdata[1:0]);
            fail_count++;
          end
          if (out_tdata[9:2] !== e.bpm) begin
            $error("reading_bpm: expected %0d, got %0d", e.bpm, out_tdata[9:2]);
            fail_count++;
          end
          if (out_tuser !== e.beat) begin
            $error("beat_seen: expected %0d, got %0d", e.beat, out_tuser);
            fail_count++;
          end
          if (out_tdata[21:10] !== e.thr) begin
            $error("threshold_now: expected %0d, got %0d", e.thr, out_tdata[21:10]);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ sim/pulse_rate_peak_detector_tb.sv @@
// Testbench top for the pulse-rate peak detector: clock, reset, register
// phases, sample stimulus and verdict. Needs prpd_pkg and the checker module.
`timescale 1ns / 1ps
module pulse_rate_peak_detector_tb;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0, in_tready, in_tlast = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid, out_tready = 1'b0, out_tuser;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          burst_left = 0, idle_cycles = 0;
  logic        hold_request = 1'b0;
  logic [15:0] clock_ms = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pulse_rate_peak_detector dut (.*);

  pulse_rate_peak_detector_checker checker_i (.*);

  // receiver: changing stall pattern, plus one long hold on request
  initial begin
    int mode, hold;
    logic held;
    mode = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        hold = 400;
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      if ($urandom_range(63) == 0) mode = $urandom_range(3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(1);
        2: out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= ($urandom_range(7) != 0);
      endcase
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("pulse_rate_peak_detector_tb NOT OK");
      $finish;
    end
  end

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one sample; called and returns at a falling edge
  task automatic send_sample(input logic [11:0] s, input logic [15:0] t, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(1)) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, t, s};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // one window of a synthetic pulse: low baseline with periodic peaks
  task automatic pulse_window(input int n);
    int period, width, step;
    logic [11:0] lo, hi, s;
    period = $urandom_range(300, 1600);
    width = $urandom_range(40, 150);
    lo = 12'($urandom_range(0, 1800));
    hi = 12'($urandom_range(2300, 4095));
    clock_ms = $urandom_range(1) ? 16'd0 : 16'($urandom);
    for (int i = 0; i < n; i++) begin
      step = $urandom_range(10, 60);
      clock_ms += 16'(step);
      s = ((clock_ms % period) < width) ? 12'(hi - $urandom_range(0, 80))
                                        : 12'(lo + $urandom_range(0, 80));
      send_sample(s, clock_ms, i == n - 1);
    end
  endtask

  task automatic random_regs();
    write_cfg(prpd_pkg::REG_START_THR, 16'($urandom_range(1500, 3000)));
    write_cfg(prpd_pkg::REG_HYST, 16'($urandom_range(0, 400)));
    write_cfg(prpd_pkg::REG_COOLDOWN, 16'($urandom_range(0, 500)));
    write_cfg(prpd_pkg::REG_MIN_BEATS, 16'($urandom_range(1, 6)));
    write_cfg(prpd_pkg::REG_ADAPT, 16'($urandom_range(0, 600)));
    write_cfg(prpd_pkg::REG_MIN_BPM, 16'($urandom_range(20, 60)));
    write_cfg(prpd_pkg::REG_MAX_BPM, 16'($urandom_range(120, 255)));
  endtask

  initial begin
    int sent;
    logic [15:0] t0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, backward time, no re-arm, ignored index
    send_sample(12'd0, 16'd0, 1'b0);
    send_sample(12'd4095, 16'd65535, 1'b0);
    send_sample(12'd0, 16'd100, 1'b0);
    send_sample(12'd4095, 16'd700, 1'b0);
    send_sample(12'd0, 16'd800, 1'b0);
    send_sample(12'd4095, 16'd200, 1'b0);
    send_sample(12'd0, 16'd300, 1'b1);
    send_sample(12'd4095, 16'd0, 1'b1);
    drain();
    write_cfg(prpd_pkg::REG_START_THR, 16'd50);
    write_cfg(prpd_pkg::REG_HYST, 16'd4095);
    write_cfg(REG_UNUSED, 16'hFFFF);
    send_sample(12'd100, 16'd0, 1'b0);
    send_sample(12'd0, 16'd1000, 1'b0);
    send_sample(12'd100, 16'd2000, 1'b1);
    drain();
    // min above max, zero min_beats, fast beats above 255 bpm
    write_cfg(prpd_pkg::REG_START_THR, 16'd2048);
    write_cfg(prpd_pkg::REG_HYST, 16'd0);
    write_cfg(prpd_pkg::REG_COOLDOWN, 16'd0);
    write_cfg(prpd_pkg::REG_MIN_BEATS, 16'd0);
    write_cfg(prpd_pkg::REG_MIN_BPM, 16'd255);
    write_cfg(prpd_pkg::REG_MAX_BPM, 16'd0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 12'd0 : 12'd4095, 16'(i * 100), i == 5);
    drain();
    write_cfg(prpd_pkg::REG_MIN_BPM, 16'd0);
    write_cfg(prpd_pkg::REG_MAX_BPM, 16'd255);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 12'd0 : 12'd4095, 16'(i * 50), i == 5);
    drain();

    // saturation: many long intervals overflow the total and the count
    write_cfg(prpd_pkg::REG_MIN_BEATS, 16'd255);
    write_cfg(prpd_pkg::REG_ADAPT, 16'd4095);
    write_cfg(prpd_pkg::REG_COOLDOWN, 16'd300);
    t0 = 16'd0;
    for (int i = 0; i < 520; i++) begin
      if (!i[0]) t0 += 16'd40000;
      send_sample(i[0] ? 12'd0 : 12'd4095, t0, i == 519);
    end
    drain();

    // register extremes then random settings, mostly well-formed windows
    write_cfg(prpd_pkg::REG_ADAPT, 16'd0);
    write_cfg(prpd_pkg::REG_MIN_BEATS, 16'd1);
    write_cfg(prpd_pkg::REG_COOLDOWN, 16'hFFFF);
    write_cfg(prpd_pkg::REG_START_THR, 16'hFFFF);
    pulse_window(30);
    drain();
    sent = 0;
    while (sent < 1350) begin
      random_regs();
      for (int w = 0; w < 6; w++) begin
        // hold the receiver off while the next window is offered
        if (sent > 600 && sent < 650) hold_request <= 1'b1;
        if ($urandom_range(4) == 0) begin
          for (int i = 0; i < 15; i++)
            send_sample(12'($urandom), 16'($urandom), $urandom_range(7) == 0);
          sent += 15;
        end else begin
          pulse_window(40);
          sent += 40;
        end
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("pulse_rate_peak_detector_tb OK");
    end else begin
      $display("pulse_rate_peak_detector_tb NOT OK");
    end
    $finish;
  end
endmodule
